@@ rtl/ffba_pkg.sv @@
package ffba_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 64;
  localparam int unsigned ADDR_BITS_DEF  = 20;
  localparam int unsigned META_BYTES_DEF = 32;

  localparam int unsigned SIZE_W   = 21;
  localparam int unsigned DADDR_W  = 20;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

endpackage

@@ rtl/first_fit_bump_allocator_top.sv @@
// First-fit heap allocator with a bump pointer. A request on s_axis (tdata:
// req_size [20:0], data_address [40:21], zero fill to 48 bits; tuser: func,
// 0 allocate, 1 free) yields exactly one response on m_axis (tdata:
// alloc_address [19:0], status [21:20], zero fill to 24 bits). The block
// table sits in one memory with a single read port and a registered read, and
// one shared compare unit walks it entry by entry, each entry in two steps
// (read, then compare). The first check settles a request at once on no
// space, a null or low address, or a free with an empty table. An allocate
// scans from entry 0 and reuses the first free entry longer than the request;
// else it appends at the bump pointer or fails. A free probes the last block
// first and, on a match, trims it and the free blocks before it; else it
// scans all entries for an inner block or reports an unknown address.
// The response holds until taken, and the next request can be accepted in
// the cycle after that. s_axis_tready is high only while the block is idle
// and the output register is empty. heap_bytes is written via cfg_we/cfg_data
// and only feeds the space check; zero means no heap.
module first_fit_bump_allocator_top #(
  parameter int unsigned MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned ADDR_BITS  = ffba_pkg::ADDR_BITS_DEF,
  parameter int unsigned META_BYTES = ffba_pkg::META_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [20:0] cfg_data,        // heap_bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,    // req_size[20:0], data_address[40:21]
  input  logic        s_axis_tuser,    // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata     // alloc_address[19:0], status[21:20]
);

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned OFF_W = 34;  // wide enough for sums without wrap
  localparam logic [OFF_W-1:0] META = OFF_W'(META_BYTES);
  localparam logic [OFF_W-1:0] ADDR_LIM = OFF_W'(64'd1 << ADDR_BITS);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_RD, S_CMP, S_TRIM_RD, S_TRIM_CMP, S_DONE
  } state_t;

  state_t              state;
  logic [20:0]         heap_bytes;
  logic [CNT_W-1:0]    block_count;
  logic [OFF_W-1:0]    bump_offset;
  logic                func;
  logic [20:0]         req_size;
  logic [19:0]         data_address;
  logic [CNT_W-1:0]    idx;
  logic                probe_last;
  logic [19:0]         out_addr;
  ffba_pkg::status_t   out_status;

  // Table memory: start, length, free mark.
  logic [ADDR_BITS-1:0] mem_start [MAX_BLOCKS];
  logic [20:0]          mem_len   [MAX_BLOCKS];
  logic                 mem_free  [MAX_BLOCKS];
  logic [ADDR_BITS-1:0] rd_start;
  logic [20:0]          rd_len;
  logic                 rd_free;
  logic [IDX_W-1:0]     rd_idx;
  logic [IDX_W-1:0]     app_idx;

  logic [OFF_W-1:0] hdr;
  logic             hit;
  logic [OFF_W-1:0] need;
  logic             append_ok;

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign hdr  = OFF_W'(data_address) - META;
  assign need = bump_offset + OFF_W'(req_size) + META;

  // Shared compare unit: either a fit test or an address match.
  always_comb begin
    if (func == ffba_pkg::FUNC_ALLOC) hit = rd_free && (rd_len > req_size);
    else hit = (OFF_W'(rd_start) == hdr);
  end

  assign m_axis_tdata = {2'b00, out_status, out_addr};

  assign rd_idx  = idx[IDX_W-1:0];
  assign app_idx = block_count[IDX_W-1:0];

  // Append write happens in the first S_DONE cycle of a non-reuse allocate that passes the address and table limits.
  assign append_ok = (state == S_DONE) && !m_axis_tvalid &&
                     !(bump_offset + META >= ADDR_LIM) &&
                     (block_count < CNT_W'(MAX_BLOCKS));

  always_ff @(posedge clk) begin
    rd_start <= mem_start[rd_idx];
    rd_len   <= mem_len[rd_idx];
    rd_free  <= mem_free[rd_idx];
    if (state == S_CMP && hit) begin
      mem_free[rd_idx] <= (func == ffba_pkg::FUNC_FREE);
    end else if (append_ok) begin
      mem_start[app_idx] <= ADDR_BITS'(bump_offset);
      mem_len[app_idx]   <= req_size;
      mem_free[app_idx]  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      heap_bytes    <= '0;
      block_count   <= '0;
      bump_offset   <= '0;
      m_axis_tvalid <= 1'b0;
      idx           <= '0;
      probe_last    <= 1'b0;
    end else begin
      if (cfg_we) heap_bytes <= cfg_data;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            func         <= s_axis_tuser;
            req_size     <= s_axis_tdata[20:0];
            data_address <= s_axis_tdata[40:21];
            out_addr     <= '0;
            out_status   <= ffba_pkg::ST_OK;
            state        <= S_CHECK;
          end
        end
        S_CHECK: begin
          idx <= '0;
          if (func == ffba_pkg::FUNC_ALLOC) begin
            if (heap_bytes == '0 || need > OFF_W'(heap_bytes)) begin
              out_status <= ffba_pkg::ST_NOSPACE;
              state      <= S_DONE;
              m_axis_tvalid <= 1'b1;
            end else if (block_count == '0) state <= S_DONE;
            else state <= S_RD;
          end else if (data_address == '0) begin
            state <= S_DONE;
            m_axis_tvalid <= 1'b1;
          end else if (OFF_W'(data_address) < META) begin
            out_status <= ffba_pkg::ST_NOTFOUND;
            state      <= S_DONE;
            m_axis_tvalid <= 1'b1;
          end else if (block_count == '0) begin
            out_status <= ffba_pkg::ST_NOTFOUND;
            state      <= S_DONE;
            m_axis_tvalid <= 1'b1;
          end else begin
            // Probe the last block first.
            idx        <= block_count - 1'b1;
            probe_last <= 1'b1;
            state      <= S_TRIM_RD;
          end
        end
        S_RD: state <= S_CMP;
        S_CMP: begin
          if (hit) begin
            if (func == ffba_pkg::FUNC_ALLOC) out_addr <= 20'(OFF_W'(rd_start) + META);
            state <= S_DONE;
            m_axis_tvalid <= 1'b1;
          end else if (idx + 1'b1 == block_count) begin
            if (func == ffba_pkg::FUNC_ALLOC) state <= S_DONE;
            else begin
              out_status <= ffba_pkg::ST_NOTFOUND;
              state      <= S_DONE;
              m_axis_tvalid <= 1'b1;
            end
          end else begin
            idx   <= idx + 1'b1;
            state <= S_RD;
          end
        end
        S_TRIM_RD: state <= S_TRIM_CMP;
        S_TRIM_CMP: begin
          if (probe_last && OFF_W'(rd_start) != hdr) begin
            // Not the last block: scan for a match instead.
            probe_last <= 1'b0;
            idx        <= '0;
            state      <= S_RD;
          end else if (probe_last || rd_free) begin
            // Drop this block and step back.
            probe_last  <= 1'b0;
            bump_offset <= OFF_W'(rd_start);
            block_count <= CNT_W'(idx);
            if (idx == '0) begin
              state <= S_DONE;
              m_axis_tvalid <= 1'b1;
            end else begin
              idx   <= idx - 1'b1;
              state <= S_TRIM_RD;
            end
          end else begin
            state <= S_DONE;
            m_axis_tvalid <= 1'b1;
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid) begin
            // Allocate with no reuse: append at the bump pointer, or fail with no space or full.
            if (bump_offset + META >= ADDR_LIM) out_status <= ffba_pkg::ST_NOSPACE;
            else if (block_count >= CNT_W'(MAX_BLOCKS)) out_status <= ffba_pkg::ST_FULL;
            else begin
              out_addr    <= 20'(bump_offset + META);
              bump_offset <= need;
              block_count <= block_count + 1'b1;
            end
            m_axis_tvalid <= 1'b1;
          end else if (m_axis_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/ffba_checker.sv @@
module ffba_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  // No new request while a response waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("ready during response");
  // Stalled response holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("response changed");
  // A failed status never grants an address.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[21:20] != 2'd0 |-> m_axis_tdata[19:0] == '0)
    else $error("address on failure");
  // Request acceptance is followed by no immediate response.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("response too early");
endmodule

bind first_fit_bump_allocator_top ffba_checker u_ffba_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
